@@ rtl/core/wnpip_pkg.sv @@
// Shared constants, types and command/status structs for the winding-number block.
package wnpip_pkg;

    // Storage and field sizes.
    localparam int MAX_VERTICES = 16;
    localparam int COORD_WIDTH  = 16;
    localparam int IDX_WIDTH    = 4;
    localparam int CNT_WIDTH    = 5;
    localparam int CNT_RESET    = 16;
    localparam int WIND_WIDTH   = 6;

    // Derived widths.
    localparam int ADDR_WIDTH = $clog2(MAX_VERTICES);
    localparam int NV_WIDTH   = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * DIFF_WIDTH;

    // Request codes carried by the req_type field.
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CLOSE,
        ST_WAIT,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  start;
        logic                  wr_en;
        logic                  rd_en;
        logic                  rd_first;
        logic [ADDR_WIDTH-1:0] rd_addr;
        logic                  close;
        logic                  load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic acc_done;
        logic out_full;
    } t_dp_sts;

endpackage

@@ rtl/core/wnpip_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module wnpip_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/wnpip_ctrl.sv @@
// Controller: input handshake, vertex count register and the per-query edge sequencer.
module wnpip_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_req_type,
    input  logic [wnpip_pkg::IDX_WIDTH-1:0]    i_vertex_index,
    input  logic                               i_cfg_wen,
    input  logic [wnpip_pkg::CNT_WIDTH-1:0]    i_cfg_wdata,
    input  logic                               i_out_ready,
    input  wnpip_pkg::t_dp_sts                 i_sts,
    output wnpip_pkg::t_dp_cmd                 o_cmd
);

    import wnpip_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_WIDTH-1:0]  r_count;
    logic [ADDR_WIDTH-1:0] r_idx;
    logic [ADDR_WIDTH-1:0] n_idx;
    logic [NV_WIDTH-1:0]   w_nv;
    logic                  w_last;

    // Vertex count in use, saturated to the size of the store.
    assign w_nv   = (int'(r_count) > MAX_VERTICES) ? NV_WIDTH'(MAX_VERTICES)
                                                   : NV_WIDTH'(r_count);
    assign w_last = (int'(r_idx) + 1) >= int'(w_nv);

    // State, edge counter and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_count <= CNT_WIDTH'(CNT_RESET);
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_wen) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type == REQ_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_idx       = '0;
                        n_state     = (w_nv == '0) ? ST_OUT : ST_READ;
                    end else begin
                        o_cmd.wr_en = int'(i_vertex_index) < MAX_VERTICES;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_addr  = r_idx;
                o_cmd.rd_first = (r_idx == '0);
                if (w_last) begin
                    n_state = ST_CLOSE;
                end else begin
                    n_idx = r_idx + ADDR_WIDTH'(1);
                end
            end
            ST_CLOSE: begin
                // Wrap-around edge from the last vertex back to the first.
                o_cmd.close = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_sts.acc_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_sts.out_full || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A finished result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!i_sts.out_full || i_out_ready))
        else $error("result loaded over an untaken word");

    // The accumulator reports completion only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.acc_done |-> (r_state == ST_WAIT))
        else $error("accumulator done outside the wait state");

endmodule

@@ rtl/core/wnpip_dp.sv @@
// Datapath: vertex memories, edge setup, exact cross products and winding accumulator.
module wnpip_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  wnpip_pkg::t_dp_cmd                    i_cmd,
    output wnpip_pkg::t_dp_sts                    o_sts,
    input  logic [wnpip_pkg::IDX_WIDTH-1:0]       i_vertex_index,
    input  logic signed [wnpip_pkg::COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [wnpip_pkg::COORD_WIDTH-1:0] i_coord_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [wnpip_pkg::WIND_WIDTH-1:0] o_winding
);

    import wnpip_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic [CW-1:0]         w_rdx;
    logic [CW-1:0]         w_rdy;
    logic signed [CW-1:0]  w_cur_x;
    logic signed [CW-1:0]  w_cur_y;

    // Query point and saved vertices.
    logic signed [CW-1:0]  r_px;
    logic signed [CW-1:0]  r_py;
    logic signed [CW-1:0]  r_first_x;
    logic signed [CW-1:0]  r_first_y;
    logic signed [CW-1:0]  r_prev_x;
    logic signed [CW-1:0]  r_prev_y;

    // Memory-read tags, aligned with the read data.
    logic                  r_rd_vld_d;
    logic                  r_rd_first_d;
    logic                  r_close_d;

    // Edge endpoints.
    logic                  w_edge_vld;
    logic signed [CW-1:0]  w_ax;
    logic signed [CW-1:0]  w_ay;
    logic signed [CW-1:0]  w_bx;
    logic signed [CW-1:0]  w_by;

    // Difference stage.
    logic                  r_e1_vld;
    logic                  r_e1_close;
    logic                  r_e1_up;
    logic                  r_e1_down;
    logic signed [DIFF_WIDTH-1:0] r_dbx;
    logic signed [DIFF_WIDTH-1:0] r_dpy;
    logic signed [DIFF_WIDTH-1:0] r_dpx;
    logic signed [DIFF_WIDTH-1:0] r_dby;

    // Product stage.
    logic                  r_e2_vld;
    logic                  r_e2_close;
    logic                  r_e2_up;
    logic                  r_e2_down;
    logic signed [PROD_WIDTH-1:0] r_p1;
    logic signed [PROD_WIDTH-1:0] r_p2;

    // Accumulator and output word.
    logic                  r_e3_close;
    logic [WIND_WIDTH-1:0] r_acc;
    logic [WIND_WIDTH-1:0] r_out;
    logic                  r_out_vld;

    // Vertex stores: one write per load, one read per edge step.
    wnpip_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_VERTICES)
    ) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (ADDR_WIDTH'(i_vertex_index)),
        .i_wdata (i_coord_x),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rdx)
    );

    wnpip_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_VERTICES)
    ) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (ADDR_WIDTH'(i_vertex_index)),
        .i_wdata (i_coord_y),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rdy)
    );

    assign w_cur_x = w_rdx;
    assign w_cur_y = w_rdy;

    // Control tags of the edge pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld_d <= 1'b0;
            r_close_d  <= 1'b0;
            r_e1_vld   <= 1'b0;
            r_e1_close <= 1'b0;
            r_e2_vld   <= 1'b0;
            r_e2_close <= 1'b0;
            r_e3_close <= 1'b0;
        end else begin
            r_rd_vld_d <= i_cmd.rd_en;
            r_close_d  <= i_cmd.close;
            r_e1_vld   <= w_edge_vld;
            r_e1_close <= r_close_d;
            r_e2_vld   <= r_e1_vld;
            r_e2_close <= r_e1_close;
            r_e3_close <= r_e2_close;
        end
    end

    // The first vertex read opens the polygon; each later one closes an edge.
    assign w_edge_vld = (r_rd_vld_d && !r_rd_first_d) || r_close_d;
    assign w_ax       = r_prev_x;
    assign w_ay       = r_prev_y;
    assign w_bx       = r_close_d ? r_first_x : w_cur_x;
    assign w_by       = r_close_d ? r_first_y : w_cur_y;

    // Point capture and the previous and first vertex.
    always_ff @(posedge i_clk) begin
        r_rd_first_d <= i_cmd.rd_first;
        if (i_cmd.start) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (r_rd_vld_d) begin
            r_prev_x <= w_cur_x;
            r_prev_y <= w_cur_y;
            if (r_rd_first_d) begin
                r_first_x <= w_cur_x;
                r_first_y <= w_cur_y;
            end
        end
    end

    // Edge differences and crossing direction.
    always_ff @(posedge i_clk) begin
        r_dbx     <= {w_bx[CW-1], w_bx} - {w_ax[CW-1], w_ax};
        r_dpy     <= {r_py[CW-1], r_py} - {w_ay[CW-1], w_ay};
        r_dpx     <= {r_px[CW-1], r_px} - {w_ax[CW-1], w_ax};
        r_dby     <= {w_by[CW-1], w_by} - {w_ay[CW-1], w_ay};
        r_e1_up   <= (w_ay <= r_py) && (w_by > r_py);
        r_e1_down <= (w_ay > r_py) && (w_by <= r_py);
    end

    // Exact cross-product terms, one multiplier per term.
    always_ff @(posedge i_clk) begin
        r_p1      <= r_dbx * r_dpy;
        r_p2      <= r_dpx * r_dby;
        r_e2_up   <= r_e1_up;
        r_e2_down <= r_e1_down;
    end

    // Winding accumulator: the sign of p1 - p2 tells which side the point is on.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_e2_vld) begin
            if (r_e2_up && (r_p1 > r_p2)) begin
                r_acc <= r_acc + WIND_WIDTH'(1);
            end else if (r_e2_down && (r_p1 < r_p2)) begin
                r_acc <= r_acc - WIND_WIDTH'(1);
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= r_acc;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_winding      = r_out;
    assign o_sts.acc_done = r_e3_close;
    assign o_sts.out_full = r_out_vld;

    // The closing edge never shares a cycle with a vertex read.
    a_close_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_close_d |-> !r_rd_vld_d)
        else $error("closing edge collides with a vertex read");

    // When completion is reported no edge is still in flight.
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e3_close |-> (!r_e1_vld && !r_e2_vld))
        else $error("edge still in flight at completion");

    // A new output word appears only on a load command.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(i_cmd.load_out))
        else $error("output word appeared without a load");

endmodule

@@ rtl/core/winding_number_point_in_polygon.sv @@
// Top level of the winding-number point-in-polygon block.
//
// Input channel (i_in_valid / o_in_ready) carries one word: a load writes vertex
// i_vertex_index of the stored polygon, a query gives the point (i_coord_x,
// i_coord_y). Coordinates are signed Q2.14. A load gives no result. A query
// gives one word on the output channel (o_out_valid / i_out_ready): the signed
// winding number, zero when the point is outside.
// i_cfg_wen writes the vertex count (0 to 31, used as 16 above 16) from
// i_cfg_wdata; write it only while the block is idle.
// A query visits one edge per cycle, reading one vertex a cycle from the vertex
// memory. Its steps are n reads, where n is the vertex count in use, the closing
// edge, a wait on the edge pipeline and the output load; a count of zero goes
// straight to the output load.
// The next word is accepted in the cycle the result appears, and loads are
// accepted one per cycle. If the receiver stalls, the output register holds the
// result and the next query runs until its own result is ready, then waits for
// the register.
// Reset clears the control state and sets the vertex count to 16; vertex
// contents are undefined until loaded.
module winding_number_point_in_polygon (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic                                     i_req_type,
    input  logic [wnpip_pkg::IDX_WIDTH-1:0]          i_vertex_index,
    input  logic signed [wnpip_pkg::COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [wnpip_pkg::COORD_WIDTH-1:0] i_coord_y,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [wnpip_pkg::WIND_WIDTH-1:0]  o_winding,
    input  logic                                     i_cfg_wen,
    input  logic [wnpip_pkg::CNT_WIDTH-1:0]          i_cfg_wdata
);

    import wnpip_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    wnpip_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_vertex_index (i_vertex_index),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_ready    (i_out_ready),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    // Vertex storage and edge arithmetic.
    wnpip_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_winding      (o_winding)
    );

endmodule
